### rtl/core/assert_macros.svh
// assertion macros used by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

### rtl/core/hafs_pkg.sv
// package: types, constants and helpers of the flip statistics block
`default_nettype none
package hafs_pkg;
  localparam int unsigned HashBitsDefault  = 64;
  localparam int unsigned CountWidthDefault = 32;
  localparam int unsigned PctW = 24;
  localparam logic [23:0] PctMax = 24'hFFFFFF;
  localparam logic [3:0]  ActiveBytesReset = 4'd8;
  localparam logic [30:0] ExpectedReset = 31'd320;

  typedef enum logic [1:0] {
    CMD_PRIME  = 2'd0,
    CMD_ACCUM  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_ACTIVE_BYTES = 1'b0,
    CFG_EXPECTED     = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS1,
    ST_DIV_BIT,
    ST_WAIT_BIT,
    ST_DIV_MEAN,
    ST_WAIT_MEAN,
    ST_PASS2,
    ST_SQ_ACC,
    ST_DIV_VAR,
    ST_WAIT_VAR,
    ST_SQRT,
    ST_WAIT_SQRT,
    ST_OUT,
    ST_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic prime;
    logic accum;
    logic clr_idx;
    logic inc_idx;
    logic bit_div_start;
    logic bit_div_take;
    logic mean_div_start;
    logic mean_div_take;
    logic sq_load;
    logic sq_acc;
    logic var_div_start;
    logic var_div_take;
    logic sqrt_start;
    logic sqrt_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_busy;
    logic sqrt_busy;
  } status_t;

  function automatic logic [23:0] sat_pct(input logic [63:0] v);
    sat_pct = (v > {40'd0, PctMax}) ? PctMax : v[23:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/hafs_stream_if.sv
// valid/ready channel interface with generic payload
`default_nettype none
interface hafs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/hafs_ram.sv
// generic ram with one write port, one read port and registered read
`default_nettype none
module hafs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/hafs_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module hafs_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [37:0] den_i,
  output logic             busy_o,
  output logic [63:0]      quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [38:0] rem_q, rem_d;
  logic [37:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [38:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      trial = {rem_q[37:0], quo_q[63]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

### rtl/core/hafs_sqrt.sv
// bitwise integer square root, two radicand bits per cycle
`default_nettype none
module hafs_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] val_i,
  output logic             busy_o,
  output logic [31:0]      root_o
);
  logic [63:0] v_q, v_d, r_q, r_d, b_q, b_d;
  logic        run_q, run_d;

  always_comb begin
    v_d = v_q;
    r_d = r_q;
    b_d = b_q;
    run_d = run_q;
    if (start_i) begin
      v_d = val_i;
      r_d = '0;
      b_d = 64'h4000_0000_0000_0000;
      run_d = 1'b1;
    end else if (run_q) begin
      if (v_q >= r_q + b_q) begin
        v_d = v_q - (r_q + b_q);
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d = b_q >> 2;
      if (b_q[0]) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) run_q <= 1'b0;
    else run_q <= run_d;
  end
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign busy_o = run_q;
  assign root_o = r_q[31:0];
endmodule
`default_nettype wire

### rtl/core/hafs_ctrl.sv
// controller state machine of the flip statistics block
`default_nettype none
module hafs_ctrl import hafs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  [1:0] in_cmd_i,
  output logic       in_ready_o,
  input  wire logic  out_valid_i,
  input  wire logic  out_ready_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);
  `include "assert_macros.svh"
  state_e state_q, state_d;
  logic   take;
  assign in_ready_o = (state_q == ST_IDLE);
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take && cmd_e'(in_cmd_i) == CMD_REPORT) state_d = ST_PASS1;
      ST_PASS1: state_d = ST_DIV_BIT;
      ST_DIV_BIT: state_d = ST_WAIT_BIT;
      ST_WAIT_BIT: begin
        if (!status_i.div_busy) state_d = status_i.idx_last ? ST_DIV_MEAN : ST_PASS1;
      end
      ST_DIV_MEAN: state_d = ST_WAIT_MEAN;
      ST_WAIT_MEAN: if (!status_i.div_busy) state_d = ST_PASS2;
      ST_PASS2: state_d = ST_SQ_ACC;
      ST_SQ_ACC: state_d = status_i.idx_last ? ST_DIV_VAR : ST_PASS2;
      ST_DIV_VAR: state_d = ST_WAIT_VAR;
      ST_WAIT_VAR: if (!status_i.div_busy) state_d = ST_SQRT;
      ST_SQRT: state_d = ST_WAIT_SQRT;
      ST_WAIT_SQRT: if (!status_i.sqrt_busy) state_d = ST_OUT;
      ST_OUT: state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_ready_i) state_d = status_i.idx_last ? ST_IDLE : ST_OUT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.prime   = take && cmd_e'(in_cmd_i) == CMD_PRIME;
        cmd_o.accum   = take && cmd_e'(in_cmd_i) == CMD_ACCUM;
        cmd_o.clr_idx = take && cmd_e'(in_cmd_i) == CMD_REPORT;
      end
      ST_DIV_BIT: cmd_o.bit_div_start = 1'b1;
      ST_WAIT_BIT: begin
        cmd_o.bit_div_take = !status_i.div_busy;
        cmd_o.inc_idx = !status_i.div_busy && !status_i.idx_last;
        cmd_o.clr_idx = !status_i.div_busy && status_i.idx_last;
      end
      ST_DIV_MEAN: cmd_o.mean_div_start = 1'b1;
      ST_WAIT_MEAN: cmd_o.mean_div_take = !status_i.div_busy;
      ST_PASS2: cmd_o.sq_load = 1'b1;
      ST_SQ_ACC: begin
        cmd_o.sq_acc = 1'b1;
        cmd_o.inc_idx = !status_i.idx_last;
        cmd_o.clr_idx = status_i.idx_last;
      end
      ST_DIV_VAR: cmd_o.var_div_start = 1'b1;
      ST_WAIT_VAR: cmd_o.var_div_take = !status_i.div_busy;
      ST_SQRT: cmd_o.sqrt_start = 1'b1;
      ST_WAIT_SQRT: cmd_o.sqrt_take = !status_i.sqrt_busy;
      ST_OUT: cmd_o.out_load = 1'b1;
      ST_OUT_WAIT: cmd_o.inc_idx = out_ready_i && !status_i.idx_last;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  `ASSERT_IMPL(a_out_only_in_out_wait, out_valid_i |-> state_q == ST_OUT_WAIT, "out valid outside output")
  `ASSERT_IMPL(a_no_take_busy, state_q != ST_IDLE |-> !in_ready_o, "ready while busy")
  `ASSERT_IMPL(a_report_starts, take && in_cmd_i == CMD_REPORT |=> state_q == ST_PASS1, "report lost")
endmodule
`default_nettype wire

### rtl/core/hafs_datapath.sv
// datapath: counters, deviation math and result register
`default_nettype none
module hafs_datapath import hafs_pkg::*; #(
  parameter int unsigned HashBits   = HashBitsDefault,
  parameter int unsigned CountWidth = CountWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  wire logic [63:0] hash_i,
  input  wire logic [3:0]  active_bytes_i,
  input  wire logic [30:0] expected_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [5:0]       bit_index_o,
  output logic [31:0]      flip_count_o,
  output logic [23:0]      bit_deviation_o,
  output logic [23:0]      mean_deviation_o,
  output logic [23:0]      std_deviation_o,
  output logic [6:0]       worst_bit_o,
  output logic             last_o
);
  localparam int unsigned IdxW = $clog2(HashBits);
  localparam logic [CountWidth-1:0] CMax = '1;

  logic [CountWidth-1:0] cnt_q [HashBits];
  logic [63:0]           prev_q;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [6:0]            nbits;
  logic [31:0]           e_val;
  logic [31:0]           c_sel;
  logic [31:0]           abs_q;
  logic [63:0]           sum_q;
  logic [63:0]           worst_q;
  logic [6:0]            wbit_q;
  logic [23:0]           mean_q, sd_q;
  logic [63:0]           sq_q;
  logic [23:0]           dd_q;
  logic [23:0]           dev_rdata;
  logic [23:0]           dev_wdata;
  logic                  div_start, div_busy, sqrt_busy;
  logic [63:0]           div_num, div_quo;
  logic [37:0]           div_den;
  logic [31:0]           sqrt_root;
  logic [3:0]            ab;

  assign ab    = (active_bytes_i == 4'd0) ? 4'd1 : (active_bytes_i > 4'd8 ? 4'd8 : active_bytes_i);
  assign nbits = ({ab, 3'b000} > 7'(HashBits)) ? 7'(HashBits) : {ab, 3'b000};
  assign e_val = (expected_i == 31'd0) ? 32'd1 : {1'b0, expected_i};
  assign c_sel = 32'(cnt_q[idx_q]);
  assign status_o.idx_last  = (7'(idx_q) + 7'd1 == nbits);
  assign status_o.div_busy  = div_busy;
  assign status_o.sqrt_busy = sqrt_busy;

  // ram is read at the next index so its data matches idx_q
  assign idx_d = cmd_i.clr_idx ? '0 : (cmd_i.inc_idx ? idx_q + 1'b1 : idx_q);

  for (genvar g = 0; g < HashBits; g++) begin : g_cnt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cnt_q[g] <= '0;
      else if (cmd_i.prime) cnt_q[g] <= '0;
      else if (cmd_i.accum && (7'(g) < nbits) && (hash_i[g] ^ prev_q[g])
               && cnt_q[g] != CMax) cnt_q[g] <= cnt_q[g] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      idx_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.prime || cmd_i.accum) prev_q <= hash_i;
      idx_q <= idx_d;
      if (cmd_i.out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // division operands per phase
  always_comb begin
    div_start = cmd_i.bit_div_start || cmd_i.mean_div_start || cmd_i.var_div_start;
    div_num = '0;
    div_den = 38'(e_val);
    if (cmd_i.bit_div_start) begin
      div_num = {32'd0, abs_q} * 64'd6553600;
    end else if (cmd_i.mean_div_start) begin
      div_num = sum_q * 64'd6553600;
      div_den = 38'(e_val) * 38'(nbits);
    end else if (cmd_i.var_div_start) begin
      div_num = sq_q;
      div_den = 38'(nbits);
    end
  end

  assign dev_wdata = sat_pct(div_quo);

  hafs_ram #(.Width(24), .Depth(HashBits)) u_dev_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.bit_div_take),
    .waddr_i(idx_q),
    .wdata_i(dev_wdata),
    .raddr_i(idx_d),
    .rdata_o(dev_rdata)
  );

  hafs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  hafs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .val_i  (sq_q),
    .busy_o (sqrt_busy),
    .root_o (sqrt_root)
  );

  always_ff @(posedge clk_i) begin
    abs_q <= (c_sel > e_val) ? c_sel - e_val : e_val - c_sel;
    if (cmd_i.clr_idx && !cmd_i.bit_div_take && !cmd_i.sq_acc) begin
      sum_q   <= '0;
      worst_q <= '0;
      wbit_q  <= 7'd64;
      sq_q    <= '0;
    end
    if (cmd_i.bit_div_take) begin
      sum_q <= sum_q + {32'd0, abs_q};
      if (div_quo > worst_q) begin
        worst_q <= div_quo;
        wbit_q  <= {1'b0, 6'(idx_q)};
      end
      if (status_o.idx_last) sq_q <= '0;
    end
    if (cmd_i.mean_div_take) mean_q <= sat_pct(div_quo);
    if (cmd_i.sq_load) dd_q <= (dev_rdata > mean_q) ? dev_rdata - mean_q : mean_q - dev_rdata;
    if (cmd_i.sq_acc) sq_q <= sq_q + 64'(dd_q) * 64'(dd_q);
    if (cmd_i.var_div_take) sq_q <= div_quo;
    if (cmd_i.sqrt_take) sd_q <= sat_pct({32'd0, sqrt_root});
    if (cmd_i.out_load) begin
      bit_index_o     <= 6'(idx_q);
      flip_count_o    <= c_sel;
      bit_deviation_o <= dev_rdata;
      mean_deviation_o <= status_o.idx_last ? mean_q : 24'd0;
      std_deviation_o  <= status_o.idx_last ? sd_q : 24'd0;
      worst_bit_o      <= status_o.idx_last ? wbit_q : 7'd0;
      last_o           <= status_o.idx_last;
    end
  end
endmodule
`default_nettype wire

### rtl/core/hash_avalanche_flip_statistics.sv
// top level of the avalanche flip statistics block
//  channel  dir  payload
//  in_if    in   command, hash_value
//  out_if   out  bit_index .. last
//  cfg      in   cfg_we_i, cfg_index_i, cfg_data_i
// prime and accumulate apply on accept; counters update in parallel
// report: a 64-step divide per bit, then mean divide,
// a square pass per bit, variance divide and 32-step root,
// then the result items, each held until out ready is high
// reset clears counters and stored hash, sets default configuration
`default_nettype none
module hash_avalanche_flip_statistics import hafs_pkg::*; #(
  parameter int unsigned HashBits   = HashBitsDefault,
  parameter int unsigned CountWidth = CountWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [63:0] hash_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       bit_index_o,
  output logic [31:0]      flip_count_o,
  output logic [23:0]      bit_deviation_o,
  output logic [23:0]      mean_deviation_o,
  output logic [23:0]      std_deviation_o,
  output logic [6:0]       worst_bit_o,
  output logic             last_o
);
  logic [3:0]  ab_q;
  logic [30:0] exp_q;
  cmd_t        cmd;
  status_t     status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_q  <= ActiveBytesReset;
      exp_q <= ExpectedReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_e'(cfg_index_i) == CFG_ACTIVE_BYTES) ab_q <= cfg_data_i[3:0];
      else exp_q <= cfg_data_i;
    end
  end

  hafs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (command_i),
    .in_ready_o (in_ready_o),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hafs_datapath #(.HashBits(HashBits), .CountWidth(CountWidth)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .hash_i          (hash_value_i),
    .active_bytes_i  (ab_q),
    .expected_i      (exp_q),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .bit_index_o     (bit_index_o),
    .flip_count_o    (flip_count_o),
    .bit_deviation_o (bit_deviation_o),
    .mean_deviation_o(mean_deviation_o),
    .std_deviation_o (std_deviation_o),
    .worst_bit_o     (worst_bit_o),
    .last_o          (last_o)
  );
endmodule
`default_nettype wire

### test/tb_hash_avalanche_flip_statistics.sv
// testbench for the avalanche flip statistics block: directed and random commands, checked per item
`default_nettype none
module tb_hash_avalanche_flip_statistics;
  import hafs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_e        command;
    logic [63:0] hash_value;
  } hash_item_t;

  typedef struct packed {
    logic [5:0]  bit_index;
    logic [31:0] flip_count;
    logic [23:0] bit_deviation;
    logic [23:0] mean_deviation;
    logic [23:0] std_deviation;
    logic [6:0]  worst_bit;
    logic        last;
  } stat_item_t;

  localparam int unsigned StallLimit = 40000;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_index;
  logic [30:0] cfg_data;

  hafs_stream_if #(.payload_t(hash_item_t)) hash_ch ();
  hafs_stream_if #(.payload_t(stat_item_t)) stat_ch ();

  hash_avalanche_flip_statistics u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (hash_ch.valid),
    .in_ready_o       (hash_ch.ready),
    .command_i        (hash_ch.payload.command),
    .hash_value_i     (hash_ch.payload.hash_value),
    .out_valid_o      (stat_ch.valid),
    .out_ready_i      (stat_ch.ready),
    .bit_index_o      (stat_ch.payload.bit_index),
    .flip_count_o     (stat_ch.payload.flip_count),
    .bit_deviation_o  (stat_ch.payload.bit_deviation),
    .mean_deviation_o (stat_ch.payload.mean_deviation),
    .std_deviation_o  (stat_ch.payload.std_deviation),
    .worst_bit_o      (stat_ch.payload.worst_bit),
    .last_o           (stat_ch.payload.last)
  );

  // predictor state
  logic [31:0] flip_cnt [64];
  logic [63:0] stored_hash;
  logic [3:0]  active_bytes_reg;
  logic [30:0] expected_reg;
  stat_item_t  stat_q [$];

  int unsigned err_count;
  int unsigned items_sent;
  int unsigned stats_checked;
  int unsigned reports_sent;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned bits_in_use();
    int unsigned n;
    n = active_bytes_reg;
    if (n == 0) n = 1;
    if (n > 8) n = 8;
    return n * 8;
  endfunction

  function automatic longint unsigned clip_pct(longint unsigned v);
    return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
  endfunction

  task automatic predict_report();
    longint unsigned e, c, a, raw, worst, sum, mean, sq, d, sd;
    longint unsigned dev [64];
    int unsigned nbits, wbit;
    stat_item_t s;
    nbits = bits_in_use();
    e = (expected_reg == 0) ? 1 : expected_reg;
    worst = 0;
    wbit = 64;
    sum = 0;
    sq = 0;
    for (int i = 0; i < nbits; i++) begin
      c = flip_cnt[i];
      a = (c > e) ? c - e : e - c;
      raw = ((a * 100) << 16) / e;
      if (raw > worst) begin
        worst = raw;
        wbit = i;
      end
      dev[i] = clip_pct(raw);
      sum += a;
    end
    mean = clip_pct(((sum * 100) << 16) / (nbits * e));
    for (int i = 0; i < nbits; i++) begin
      d = (dev[i] > mean) ? dev[i] - mean : mean - dev[i];
      sq += d * d;
    end
    sd = clip_pct(root_floor(sq / nbits));
    for (int i = 0; i < nbits; i++) begin
      s = '0;
      s.bit_index = i[5:0];
      s.flip_count = flip_cnt[i];
      s.bit_deviation = dev[i][23:0];
      if (i == nbits - 1) begin
        s.mean_deviation = mean[23:0];
        s.std_deviation = sd[23:0];
        s.worst_bit = wbit[6:0];
        s.last = 1'b1;
      end
      stat_q.push_back(s);
    end
  endtask

  task automatic predict_item(hash_item_t it);
    logic [63:0] diff;
    case (it.command)
      CMD_PRIME: begin
        for (int i = 0; i < 64; i++) flip_cnt[i] = '0;
        stored_hash = it.hash_value;
      end
      CMD_ACCUM: begin
        diff = it.hash_value ^ stored_hash;
        for (int i = 0; i < bits_in_use(); i++)
          if (diff[i] && flip_cnt[i] != 32'hFFFF_FFFF) flip_cnt[i] = flip_cnt[i] + 1;
        stored_hash = it.hash_value;
      end
      CMD_REPORT: begin
        predict_report();
        reports_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic send_hash(cmd_e cmd, logic [63:0] h);
    hash_item_t it;
    int unsigned gap;
    it.command = cmd;
    it.hash_value = h;
    hash_ch.valid <= 1'b1;
    hash_ch.payload <= it;
    do @(posedge clk_i); while (!hash_ch.ready);
    predict_item(it);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      hash_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    hash_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (stat_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE_BYTES) active_bytes_reg = value[3:0];
    else expected_reg = value;
  endtask

  task automatic set_cfg(logic [3:0] nbytes, logic [30:0] e);
    wait_drained();
    write_cfg(CFG_ACTIVE_BYTES, {27'd0, nbytes});
    @(posedge clk_i);
    write_cfg(CFG_EXPECTED, e);
  endtask

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    err_count++;
  endtask

  // result checker and stall watchdog
  always @(posedge clk_i) begin
    stat_item_t g, w;
    if (rst_ni) begin
      if ((hash_ch.valid && hash_ch.ready) || (stat_ch.valid && stat_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("tb: failure");
        $finish;
      end
      if (stat_ch.valid && stat_ch.ready) begin
        g = stat_ch.payload;
        if (stat_q.size() == 0) begin
          report_mismatch("unexpected item", g.bit_index, 0);
        end else begin
          w = stat_q.pop_front();
          stats_checked++;
          if (g.bit_index !== w.bit_index) report_mismatch("bit_index", g.bit_index, w.bit_index);
          if (g.flip_count !== w.flip_count)
            report_mismatch("flip_count", g.flip_count, w.flip_count);
          if (g.bit_deviation !== w.bit_deviation)
            report_mismatch("bit_deviation", g.bit_deviation, w.bit_deviation);
          if (g.mean_deviation !== w.mean_deviation)
            report_mismatch("mean_deviation", g.mean_deviation, w.mean_deviation);
          if (g.std_deviation !== w.std_deviation)
            report_mismatch("std_deviation", g.std_deviation, w.std_deviation);
          if (g.worst_bit !== w.worst_bit) report_mismatch("worst_bit", g.worst_bit, w.worst_bit);
          if (g.last !== w.last) report_mismatch("last", g.last, w.last);
        end
      end
    end
  end

  // result side back pressure
  initial begin
    stat_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 9) < 2) begin
        stat_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        stat_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
        stat_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  task automatic test_flip_basics();
    set_cfg(4'd8, 31'd1);
    send_hash(CMD_PRIME, '0);
    send_hash(CMD_ACCUM, '1);
    send_hash(CMD_REPORT, '0);
    send_hash(CMD_ACCUM, '1);
    send_hash(CMD_ACCUM, 64'hAAAA_AAAA_AAAA_AAAA);
    send_hash(CMD_NONE, '1);
    send_hash(CMD_REPORT, '1);
    send_hash(CMD_PRIME, '1);
    send_hash(CMD_ACCUM, 64'h5555_5555_5555_5555);
    send_hash(CMD_ACCUM, 64'h5555_5555_5555_5555);
    send_hash(CMD_REPORT, 64'h1234_5678_9ABC_DEF0);
  endtask

  task automatic test_config_extremes();
    set_cfg(4'd0, 31'd0);
    send_hash(CMD_PRIME, 64'h0F0F_0F0F_0F0F_0F0F);
    send_hash(CMD_ACCUM, 64'hF0F0_F0F0_F0F0_F0F0);
    send_hash(CMD_REPORT, '0);
    set_cfg(4'd15, 31'h7FFF_FFFF);
    send_hash(CMD_ACCUM, '1);
    send_hash(CMD_REPORT, '0);
    set_cfg(4'd3, 31'd2);
    send_hash(CMD_ACCUM, 64'h0000_0000_00FF_0F0F);
    send_hash(CMD_ACCUM, 64'hFFFF_FFFF_FF00_F0F0);
    send_hash(CMD_REPORT, '0);
    set_cfg(4'd9, 31'd1);
    send_hash(CMD_REPORT, '0);
  endtask

  task automatic test_random_runs();
    int unsigned k;
    while (items_sent < 455) begin
      k = $urandom_range(1, 24);
      case ($urandom_range(0, 5))
        0: set_cfg(4'($urandom_range(0, 15)), 31'($urandom));
        1: set_cfg(4'($urandom_range(1, 2)), 31'($urandom_range(0, 3)));
        default: set_cfg(4'($urandom_range(1, 8)), 31'((k + 1) / 2 + $urandom_range(0, 2)));
      endcase
      send_hash(CMD_PRIME, {$urandom, $urandom});
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 19) == 0) send_hash(cmd_e'($urandom_range(0, 3)), {$urandom, $urandom});
        else send_hash(CMD_ACCUM, {$urandom, $urandom});
      end
      send_hash(CMD_REPORT, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACTIVE_BYTES;
    cfg_data = '0;
    hash_ch.valid = 1'b0;
    hash_ch.payload = '0;
    for (int i = 0; i < 64; i++) flip_cnt[i] = '0;
    stored_hash = '0;
    active_bytes_reg = ActiveBytesReset;
    expected_reg = ExpectedReset;
    err_count = 0;
    items_sent = 0;
    stats_checked = 0;
    reports_sent = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_hash(CMD_REPORT, '0);
    test_flip_basics();
    test_config_extremes();
    test_random_runs();
    wait_drained();
    $display("sent %0d hash items with %0d reports", items_sent, reports_sent);
    $display("checked %0d statistics items, %0d mismatches", stats_checked, err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/hafs_pkg.sv
rtl/core/hafs_stream_if.sv
rtl/core/hafs_ram.sv
rtl/core/hafs_div.sv
rtl/core/hafs_sqrt.sv
rtl/core/hafs_ctrl.sv
rtl/core/hafs_datapath.sv
rtl/core/hash_avalanche_flip_statistics.sv
test/tb_hash_avalanche_flip_statistics.sv
